[hw/rtl/sha256_pkg.sv]
// Package of types, constants and round functions for the SHA-256 byte-stream hasher.
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPRESS,
    ST_PAD,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load_byte;
    logic [7:0] pad_byte;
    logic use_pad;
    logic start_round;
    logic round_step;
    logic finish_block;
    logic clear_hash;
  } dp_cmd_t;

  typedef struct packed {
    logic round_last;
    logic [5:0] fill;
  } dp_status_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned r);
    rotr = (x >> r) | (x << (32 - r));
  endfunction

endpackage

[hw/rtl/sha256_byte_stream_hasher.sv]
// Top level of the SHA-256 byte-stream hasher.
// The block takes one message byte per item while its 64-byte buffer fills; the item that
// completes a block is followed by compression, one round per cycle in a single round unit,
// during which no item is taken. An end-of-message item runs the padding at one byte per cycle,
// with one or two further compressions, and once the hash words have taken the last compression
// offers the eight digest words in turn, each held while the receiver stalls, word 0 first,
// after which the hash state returns to its initial value. No item is taken during padding or
// while digest words are offered.
module sha256_byte_stream_hasher
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sha256_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .byte_valid(byte_valid), .end_of_message(end_of_message),
    .out_valid(out_valid), .out_stall(out_stall), .word_index(word_index),
    .last_word(last_word), .status(status), .cmd(cmd)
  );

  sha256_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .data_byte(data_byte), .sel_index(word_index),
    .status(status), .hash_word(digest_word)
  );

endmodule

[hw/rtl/sha256_datapath.sv]
// Datapath of the SHA-256 hasher: message block and schedule window, round unit and hash words.
module sha256_datapath
  import sha256_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  dp_cmd_t      cmd,
  input  logic [7:0]   data_byte,
  input  logic [2:0]   sel_index,
  output dp_status_t   status,
  output logic [31:0]  hash_word
);

  logic [5:0]  fill;
  logic [5:0]  round;
  logic        finish_pending;
  logic [31:0] hash [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [7:0]  in_byte;
  logic [31:0] w_new, wt, s0, s1, ch, mj, t1, t2, sg0, sg1;

  assign in_byte = cmd.use_pad ? cmd.pad_byte : data_byte;

  always_comb begin
    sg1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    sg0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    w_new = sg1 + w[9] + sg0 + w[0];
    wt = (round < 6'd16) ? w[0] : w_new;
    s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + s1 + ch + ROUND_K[round] + wt;
    s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = s0 + mj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.clear_hash) begin
      fill <= '0;
    end else if (cmd.load_byte) begin
      fill <= fill + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round <= '0;
    end else if (cmd.start_round) begin
      round <= '0;
    end else if (cmd.round_step) begin
      round <= round + 6'd1;
    end
  end

  // Bytes are shifted into the schedule window, so that after 64 bytes it holds the block.
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= {w[i][23:0], w[i+1][31:24]};
      end
      w[15] <= {w[15][23:0], in_byte};
    end else if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= wt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_round) begin
      for (int k = 0; k < 8; k++) begin
        v[k] <= hash[k];
      end
    end else if (cmd.round_step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  // The hash words add in the working variables once the last round has been registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      finish_pending <= 1'b0;
    end else begin
      finish_pending <= cmd.finish_block;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_hash) begin
      for (int k = 0; k < 8; k++) begin
        hash[k] <= INIT_HASH[k];
      end
    end else if (finish_pending) begin
      for (int k = 0; k < 8; k++) begin
        hash[k] <= hash[k] + v[k];
      end
    end
  end

  assign status.round_last = (round == 6'd63);
  assign status.fill = fill;
  assign hash_word = hash[sel_index];

endmodule

[hw/rtl/sha256_controller.sv]
// Controller state machine of the SHA-256 hasher: sequencing of absorb, compression, padding and digest output.
module sha256_controller
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  word_index,
  output logic        last_word,
  input  dp_status_t  status,
  output dp_cmd_t     cmd
);

  ctrl_state_t state, state_next;
  logic        pending_end, pending_end_next;
  logic [60:0] byte_count, byte_count_next;
  logic [2:0]  widx, widx_next;
  logic        after_comp;
  logic        in_acc, pad_load, out_acc;
  logic        mark_done, mark_done_next, len_ready, len_ready_next, pad_len_phase;
  logic [63:0] bits;
  logic [2:0]  len_sel;

  assign bits = {byte_count, 3'b000};
  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign len_sel = status.fill[2:0];
  assign pad_load = (state == ST_PAD);

  always_comb begin
    state_next = state;
    pending_end_next = pending_end;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (byte_valid && status.fill == 6'd63) begin
            state_next = ST_COMPRESS;
            pending_end_next = end_of_message;
          end else if (end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_COMPRESS: begin
        if (status.round_last) begin
          state_next = pending_end ? ST_PAD : ST_IDLE;
          if (!pending_end) begin
            pending_end_next = 1'b0;
          end
        end
      end
      ST_PAD: begin
        pending_end_next = 1'b1;
        if (status.fill == 6'd63) begin
          state_next = ST_COMPRESS;
        end else if (status.fill == 6'd0 && after_comp) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc && widx == 3'd7) begin
          state_next = ST_IDLE;
          pending_end_next = 1'b0;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // A pad pass is complete when the compression just run held the length field.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pending_end <= 1'b0;
      byte_count <= '0;
      widx <= '0;
      after_comp <= 1'b0;
    end else begin
      state <= state_next;
      pending_end <= pending_end_next;
      byte_count <= byte_count_next;
      widx <= widx_next;
      if (state == ST_PAD && state_next == ST_COMPRESS) begin
        after_comp <= (status.fill == 6'd63) && (len_sel == 3'd7) && pad_len_phase;
      end else if (state == ST_EMIT || state == ST_IDLE) begin
        after_comp <= 1'b0;
      end
    end
  end

  // Padding phases: the mark byte, then zeros to offset 56, then eight length bytes.
  // The length goes into the block that holds the mark only when the mark lies before
  // offset 56; otherwise it goes into the next block.
  always_ff @(posedge clk) begin
    if (rst) begin
      mark_done <= 1'b0;
      len_ready <= 1'b0;
    end else begin
      mark_done <= mark_done_next;
      len_ready <= len_ready_next;
    end
  end

  always_comb begin
    mark_done_next = mark_done;
    len_ready_next = len_ready;
    if (state == ST_PAD && !after_comp) begin
      mark_done_next = 1'b1;
      if (status.fill == 6'd63) begin
        len_ready_next = 1'b1;
      end else if (!mark_done) begin
        len_ready_next = (status.fill < LEN_OFFSET);
      end
    end
    if (state == ST_EMIT) begin
      mark_done_next = 1'b0;
      len_ready_next = 1'b0;
    end
  end

  assign pad_len_phase = mark_done && len_ready && (status.fill >= LEN_OFFSET);

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    byte_count_next = byte_count;
    widx_next = widx;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_acc && byte_valid) begin
          cmd.load_byte = 1'b1;
          byte_count_next = byte_count + 61'd1;
          if (status.fill == 6'd63) begin
            cmd.start_round = 1'b1;
          end
        end
      end
      ST_COMPRESS: begin
        cmd.round_step = 1'b1;
        if (status.round_last) begin
          cmd.finish_block = 1'b1;
        end
      end
      ST_PAD: begin
        if (!(status.fill == 6'd0 && after_comp)) begin
          cmd.load_byte = pad_load;
          cmd.use_pad = 1'b1;
          if (!mark_done) begin
            cmd.pad_byte = PAD_MARK;
          end else if (pad_len_phase) begin
            cmd.pad_byte = bits[8*(7-len_sel) +: 8];
          end else begin
            cmd.pad_byte = 8'h00;
          end
          if (status.fill == 6'd63) begin
            cmd.start_round = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_acc) begin
          widx_next = widx + 3'd1;
          if (widx == 3'd7) begin
            cmd.clear_hash = 1'b1;
            byte_count_next = '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign word_index = widx;
  assign last_word = (widx == 3'd7);

endmodule
